### hw/rtl/fpdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdf_pkg
// Shared types and constants for the fixed-point decimal formatter.
// ----------------------------------------------------------------------------
package fpdf_pkg;

  localparam int DIGIT_BITS = 4;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_POINT = 8'h2E;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  digit_count;
    logic [3:0]  fraction_digits;
  } fpdf_in_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } fpdf_out_t;

  // status of a sequenced unit
  typedef struct packed {
    logic busy;
    logic done;
  } fpdf_stat_t;

endpackage

### hw/rtl/fpdf_bin2bcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdf_bin2bcd
// Iterative shift-and-add-3 binary to BCD converter, one bit per cycle.
// ----------------------------------------------------------------------------
module fpdf_bin2bcd #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 10
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [VALUE_BITS-1:0]                   operand,
  output logic [MAX_DIGITS*fpdf_pkg::DIGIT_BITS-1:0] bcd,
  output fpdf_pkg::fpdf_stat_t                    stat
);
  import fpdf_pkg::*;

  localparam int BW  = MAX_DIGITS * DIGIT_BITS;
  localparam int BCW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] shift_r, shift_nxt;
  logic [BW-1:0]         bcd_r, bcd_nxt, adj;
  logic [BCW-1:0]        cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  // add 3 to every digit of 5 or more before the doubling shift; the carry
  // out of the top digit is dropped, which keeps the value mod 10^MAX_DIGITS
  always_comb begin
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (bcd_r[d*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
        adj[d*DIGIT_BITS +: DIGIT_BITS] = bcd_r[d*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
      end else begin
        adj[d*DIGIT_BITS +: DIGIT_BITS] = bcd_r[d*DIGIT_BITS +: DIGIT_BITS];
      end
    end
  end

  always_comb begin
    shift_nxt = shift_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      shift_nxt = operand;
      bcd_nxt   = '0;
      cnt_nxt   = BCW'(VALUE_BITS);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      bcd_nxt   = {adj[BW-2:0], shift_r[VALUE_BITS-1]};
      shift_nxt = {shift_r[VALUE_BITS-2:0], 1'b0};
      cnt_nxt   = cnt_r - BCW'(1);
      if (cnt_r == BCW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    bcd_r   <= bcd_nxt;
  end

  assign bcd       = bcd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### hw/rtl/fpdf_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdf_emit
// Character serializer: walks the BCD digits MSB first, inserts the point,
// and drives the registered output channel.
// ----------------------------------------------------------------------------
module fpdf_emit #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic [$clog2(MAX_DIGITS+1)-1:0]            num_digits,
  input  logic [$clog2(MAX_DIGITS+1)-1:0]            num_frac,
  input  logic [MAX_DIGITS*fpdf_pkg::DIGIT_BITS-1:0] bcd,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output fpdf_pkg::fpdf_out_t                        out_data,
  output fpdf_pkg::fpdf_stat_t                       stat
);
  import fpdf_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic            active_r, active_nxt;
  logic            done_r, done_nxt;
  logic            point_r, point_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]   nf_r, nf_nxt;
  logic            out_valid_r, out_valid_nxt;
  fpdf_out_t       out_data_r, out_data_nxt;
  logic [CW-1:0]   rem_m1;
  logic [DIGIT_BITS-1:0] cur_digit;
  logic            load;

  assign rem_m1    = rem_r - CW'(1);
  assign cur_digit = DIGIT_BITS'(bcd >> {rem_m1, 2'b00});
  assign load      = active_r && (!out_valid_r || out_ready);

  always_comb begin
    active_nxt    = active_r;
    done_nxt      = 1'b0;
    point_nxt     = point_r;
    rem_nxt       = rem_r;
    nf_nxt        = nf_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (start) begin
      active_nxt = 1'b1;
      rem_nxt    = num_digits;
      nf_nxt     = num_frac;
      point_nxt  = (num_frac != '0);
    end else if (load) begin
      out_valid_nxt = 1'b1;
      if (point_r && (rem_r == nf_r)) begin
        out_data_nxt.text_char = ASCII_POINT;
        out_data_nxt.last_char = 1'b0;
        point_nxt              = 1'b0;
      end else begin
        out_data_nxt.text_char = ASCII_ZERO + {4'b0000, cur_digit};
        out_data_nxt.last_char = (rem_r == CW'(1));
        rem_nxt                = rem_m1;
        if (rem_r == CW'(1)) begin
          active_nxt = 1'b0;
          done_nxt   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      done_r      <= 1'b0;
      point_r     <= 1'b0;
      rem_r       <= '0;
      nf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      done_r      <= done_nxt;
      point_r     <= point_nxt;
      rem_r       <= rem_nxt;
      nf_r        <= nf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign stat.busy = active_r;
  assign stat.done = done_r;

endmodule

### hw/rtl/fixed_point_decimal_formatter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter_unit
// Formats an unsigned binary value as fixed-width decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one number with its digit
//   count and fraction digit count. The output channel (out_valid/out_ready/
//   out_data) returns its text one character per transaction, MSB digit
//   first, leading zeros kept, '.' before the fraction digits; last_char
//   flags the final character. A digit count of zero yields no characters.
// Timing:
//   The binary-to-BCD converter shifts one bit per cycle, then the
//   serializer emits the text, one character per cycle while out_ready
//   is high. in_ready is low from acceptance until the cycle after the
//   last character is loaded.
// Reset and stall:
//   rst_n (synchronous) returns the sequencer to idle and drops out_valid.
//   When out_ready is low the current character holds in the output
//   register and the serializer waits.
// ----------------------------------------------------------------------------
module fixed_point_decimal_formatter_unit #(
  parameter int MAX_DIGITS = 10,
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fpdf_pkg::fpdf_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fpdf_pkg::fpdf_out_t out_data
);
  import fpdf_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                nd_r, nd_nxt, nd_in;
  logic [CW-1:0]                nf_r, nf_nxt, nf_in;
  logic                         conv_start;
  logic                         emit_start;
  logic [MAX_DIGITS*DIGIT_BITS-1:0] bcd;
  fpdf_stat_t                   bcd_stat;
  fpdf_stat_t                   emit_stat;

  // saturate digit count, then clamp fraction count to it
  always_comb begin
    if (32'(in_data.digit_count) > MAX_DIGITS) begin
      nd_in = CW'(MAX_DIGITS);
    end else begin
      nd_in = CW'(in_data.digit_count);
    end
    if (32'(in_data.fraction_digits) > 32'(nd_in)) begin
      nf_in = nd_in;
    end else begin
      nf_in = CW'(in_data.fraction_digits);
    end
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign conv_start = in_valid && in_ready && (nd_in != '0);
  assign emit_start = (state_r == ST_CONV) && bcd_stat.done;

  always_comb begin
    state_nxt = state_r;
    nd_nxt    = nd_r;
    nf_nxt    = nf_r;
    case (state_r)
      ST_IDLE: begin
        if (conv_start) begin
          nd_nxt    = nd_in;
          nf_nxt    = nf_in;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bcd_stat.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_stat.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nd_r <= nd_nxt;
    nf_r <= nf_nxt;
  end

  fpdf_bin2bcd #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_bin2bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (conv_start),
    .operand(VALUE_BITS'(in_data.value)),
    .bcd    (bcd),
    .stat   (bcd_stat)
  );

  fpdf_emit #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (emit_start),
    .num_digits(nd_r),
    .num_frac  (nf_r),
    .bcd       (bcd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (emit_stat)
  );

`ifndef SYNTHESIS
  a_idle_conv_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !bcd_stat.busy)
    else $error("converter busy while accepting input");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(bcd_stat.busy && emit_stat.busy))
    else $error("converter and serializer active together");

  a_conv_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    bcd_stat.done |-> (state_r == ST_CONV))
    else $error("conversion finished outside CONV");

  a_emit_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    emit_stat.done |-> (state_r == ST_EMIT))
    else $error("serializer finished outside EMIT");
`endif

endmodule
